@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros for the ring buffer lock manager RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rblm_pkg.sv @@
// Shared types, codes and helpers of the ring buffer lock manager.
// No dependencies; imported by every module of the block.
package rblm_pkg;

  localparam int LOCK_SLOTS_DEF       = 8;
  localparam int MAX_BUFFER_BYTES_DEF = 65536;
  localparam int CFG_W                = 17;
  localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 17'd65536;
  localparam int IN_DATA_W            = 104;
  localparam int OUT_DATA_W           = 128;
  localparam int Q_DEPTH              = 2;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_LOCK   = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] cnt;
    logic        wrap;
    logic        second;
    logic        lock_bad;
  } item_t;

  // Size and position width: wide enough for the register and for the fallback size.
  function automatic int size_width(input int max_bytes);
    int w;
    w = $clog2(max_bytes + 1);
    return (w > CFG_W) ? w : CFG_W;
  endfunction

  function automatic logic [31:0] lockable(input logic [31:0] size, input logic [31:0] r,
                                           input logic [31:0] w);
    return (r < w) ? (size + r - w) : (size - r + w);
  endfunction

endpackage

@@ hw/rtl/rblm_div.sv @@
// Bit-serial remainder unit: 32-bit dividend modulo the buffer size.
// Depends on rblm_pkg for the size width.
module rblm_div import rblm_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [size_width(MAX_BUFFER_BYTES)-1:0] divisor,
  output logic                done,
  output logic [size_width(MAX_BUFFER_BYTES)-1:0] remainder
);
  localparam int SW     = size_width(MAX_BUFFER_BYTES);
  localparam int STEPS  = 32;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [31:0]       num;
  logic [SW-1:0]     den;
  logic [SW:0]       shifted;

  assign shifted = {remainder, num[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        num       <= dividend;
        den       <= divisor;
        remainder <= '0;
      end else if (busy) begin
        // restore or subtract one bit a cycle
        if (shifted >= {1'b0, den}) begin
          remainder <= SW'(shifted - {1'b0, den});
        end else begin
          remainder <= shifted[SW-1:0];
        end
        num  <= {num[30:0], 1'b0};
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/rblm_front.sv @@
// Front end: unpacks incoming words and classifies them before queueing.
// Depends on rblm_pkg for item_t and action codes.
module rblm_front import rblm_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
  input  logic [size_width(MAX_BUFFER_BYTES)-1:0] size,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);
  logic [31:0] size32;

  assign size32   = 32'(size);
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.action = s_tuser;
    q_item.p1     = s_tdata[31:0];
    q_item.p2     = s_tdata[63:32];
    q_item.cnt    = s_tdata[95:64];
    q_item.wrap   = s_tdata[96];
    q_item.second = s_tdata[97];
    // argument checks that need no position or table state
    q_item.lock_bad = (s_tuser == ACT_LOCK) &&
                      ((s_tdata[95:64] == 32'd0) || (s_tdata[31:0] > size32) ||
                       (s_tdata[95:64] > size32));
  end
endmodule

@@ hw/rtl/rblm_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on rblm_pkg for item_t.
module rblm_queue import rblm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);
  localparam int PTR_W = $clog2(Q_DEPTH);

  item_t            entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/rblm_back.sv @@
// Back end: positions, lock table scan, read spans and the result register.
// Depends on rblm_pkg and instantiates rblm_div.
module rblm_back import rblm_pkg::*; #(
  parameter int LOCK_SLOTS       = LOCK_SLOTS_DEF,
  parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [size_width(MAX_BUFFER_BYTES)-1:0] size,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser
);
  localparam int SW    = size_width(MAX_BUFFER_BYTES);
  localparam int IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV2, S_SET_FIN, S_LOCK_CHK, S_SCAN, S_LOCK_FIN,
    S_READ1, S_READ2, S_READ3
  } state_t;

  typedef struct packed {
    logic [SW-1:0] off;
    logic [SW-1:0] len;
    logic          wrapped;
  } slot_t;

  state_t            state;
  item_t             cur;
  logic [31:0]       a1, a2;
  logic [SW-1:0]     read_pos, write_pos;
  logic [LOCK_SLOTS-1:0] slot_valid;
  logic [IDX_W:0]    issue_idx;
  logic              chk_en;
  logic [IDX_W-1:0]  chk_idx;
  logic              conflict, free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [SW-1:0]     wamt;
  logic [31:0]       maxb, room, cc;

  logic [1:0]  res_status;
  logic [16:0] res_off1, res_len1, res_len2, res_rp, res_wp;
  logic        res_has2;
  logic [17:0] res_total, res_lk;
  logic        out_valid;

  slot_t            slot_mem [LOCK_SLOTS];
  slot_t            rd_slot;
  logic             mem_we;
  logic [IDX_W-1:0] mem_raddr;
  slot_t            mem_wdata;

  logic              div_start, div_done;
  logic [31:0]       div_dividend;
  logic [SW-1:0]     div_rem;

  logic [31:0] size32, r32, w32, lk32, len1_rd;
  logic [SW:0] lock_end, slot_end, lock_sum;
  logic        same_start, overlap, pop_now;

  assign size32 = 32'(size);
  assign r32    = 32'(read_pos);
  assign w32    = 32'(write_pos);
  assign lk32   = lockable(size32, r32, w32);

  assign pop_now = (state == S_IDLE) && q_valid && !out_valid;
  assign q_pop   = pop_now;

  assign div_start    = (pop_now && (q_item.action == ACT_SET) && q_item.wrap) ||
                        ((state == S_DIV1) && div_done);
  assign div_dividend = (state == S_DIV1) ? cur.p2 : q_item.p1;

  rblm_div #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size),
    .done     (div_done),
    .remainder(div_rem)
  );

  // slot store: one write port, one registered read port
  assign mem_raddr = issue_idx[IDX_W-1:0];
  assign mem_we    = (state == S_LOCK_FIN) && !conflict && free_found;
  assign mem_wdata = '{off: cur.p1[SW-1:0], len: cur.cnt[SW-1:0], wrapped: (wamt != '0)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[free_idx] <= mem_wdata;
    end
    rd_slot <= slot_mem[mem_raddr];
  end

  assign lock_sum   = {1'b0, cur.p1[SW-1:0]} + {1'b0, cur.cnt[SW-1:0]};
  assign lock_end   = lock_sum;
  assign slot_end   = {1'b0, rd_slot.off} + {1'b0, rd_slot.len};
  assign same_start = (rd_slot.off == cur.p1[SW-1:0]) && (rd_slot.wrapped == (wamt != '0));
  assign overlap    = !((slot_end <= {1'b0, cur.p1[SW-1:0]}) || (lock_end <= {1'b0, rd_slot.off}));
  assign len1_rd    = (cc < room) ? cc : room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      read_pos   <= '0;
      write_pos  <= '0;
      slot_valid <= '0;
      chk_en     <= 1'b0;
      issue_idx  <= '0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_now) begin
            cur        <= q_item;
            res_status <= ST_OK;
            res_off1   <= '0;
            res_len1   <= '0;
            res_has2   <= 1'b0;
            res_len2   <= '0;
            res_total  <= '0;
            res_rp     <= read_pos[16:0];
            res_wp     <= write_pos[16:0];
            res_lk     <= lk32[17:0];
            issue_idx  <= '0;
            chk_en     <= 1'b0;
            conflict   <= 1'b0;
            free_found <= 1'b0;
            free_idx   <= '0;
            unique case (q_item.action)
              ACT_SET: begin
                if (q_item.wrap) begin
                  state <= S_DIV1;
                end else begin
                  a1    <= q_item.p1;
                  a2    <= q_item.p2;
                  state <= S_SET_FIN;
                end
              end
              ACT_LOCK:   state <= S_LOCK_CHK;
              ACT_UNLOCK: state <= S_SCAN;
              default:    state <= S_READ1;
            endcase
          end
        end
        S_DIV1: begin
          if (div_done) begin
            a1    <= 32'(div_rem);
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            a2    <= 32'(div_rem);
            state <= S_SET_FIN;
          end
        end
        S_SET_FIN: begin
          if ((a1 > size32) || (a2 > size32)) begin
            res_status <= ST_INVALID;
          end else begin
            read_pos  <= a1[SW-1:0];
            write_pos <= a2[SW-1:0];
            res_rp    <= a1[16:0];
            res_wp    <= a2[16:0];
            res_lk    <= 18'(lockable(size32, a1, a2));
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_LOCK_CHK: begin
          if (cur.lock_bad || (lk32 < cur.cnt)) begin
            res_status <= ST_INVALID;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            wamt  <= (lock_sum > {1'b0, size}) ? SW'(lock_sum - {1'b0, size}) : '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one slot read a cycle, check it the cycle after;
          // the check enable drops by itself once every slot is issued
          if (issue_idx < (IDX_W+1)'(LOCK_SLOTS)) begin
            issue_idx <= issue_idx + 1'b1;
          end
          chk_en  <= (issue_idx < (IDX_W+1)'(LOCK_SLOTS));
          chk_idx <= issue_idx[IDX_W-1:0];
          if (chk_en) begin
            if (cur.action == ACT_UNLOCK) begin
              if (slot_valid[chk_idx] && (32'(rd_slot.off) == cur.p1) &&
                  (rd_slot.wrapped == cur.second)) begin
                slot_valid[chk_idx] <= 1'b0;
                out_valid           <= 1'b1;
                state               <= S_IDLE;
              end else if (chk_idx == IDX_W'(LOCK_SLOTS - 1)) begin
                res_status <= ST_INVALID;
                out_valid  <= 1'b1;
                state      <= S_IDLE;
              end
            end else begin
              if (slot_valid[chk_idx]) begin
                if (same_start || overlap) begin
                  conflict <= 1'b1;
                end
              end else if (!free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_idx == IDX_W'(LOCK_SLOTS - 1)) begin
                state <= S_LOCK_FIN;
              end
            end
          end
        end
        S_LOCK_FIN: begin
          if (conflict) begin
            res_status <= ST_INVALID;
          end else if (!free_found) begin
            res_status <= ST_FULL;
          end else begin
            slot_valid[free_idx] <= 1'b1;
            res_off1 <= cur.p1[16:0];
            res_len1 <= 17'(32'(cur.cnt[SW-1:0]) - 32'(wamt));
            res_has2 <= (wamt != '0);
            res_len2 <= wamt[16:0];
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_READ1: begin
          maxb  <= (r32 < w32) ? (w32 - r32) : (size32 + w32 - r32);
          room  <= size32 - r32;
          state <= S_READ2;
        end
        S_READ2: begin
          cc    <= (cur.cnt > maxb) ? maxb : cur.cnt;
          state <= S_READ3;
        end
        S_READ3: begin
          res_off1  <= read_pos[16:0];
          res_len1  <= len1_rd[16:0];
          res_has2  <= (len1_rd < cc);
          res_len2  <= 17'(cc - len1_rd);
          res_total <= cc[17:0];
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {6'd0, res_lk, res_wp, res_rp, res_total, res_len2, res_has2,
                     res_len1, res_off1};
endmodule

@@ hw/rtl/ring_buffer_region_lock_manager.sv @@
// Top level of the ring buffer region lock manager.
// Depends on rblm_pkg, assert_macros.svh, rblm_front, rblm_queue and rblm_back.

// Tracks the read and write positions of a circular buffer and a table of locked
// regions; the data itself lives elsewhere. Each input word (tuser = action) sets
// positions, locks, unlocks or sizes a read, and yields one result word (tuser =
// status). Words pass through a two-entry queue, so the input side keeps taking
// words, until the queue fills, while a result waits. In the back end, a set with wrap
// takes two passes of the shared bit-serial remainder unit, and lock and unlock
// scan the lock table one slot a cycle through the slot store's single read port;
// an unlock stops at its matching slot. Items run one at a time. The lock table
// starts empty out of reset through per-slot valid bits; no clearing pass.
`include "assert_macros.svh"

module ring_buffer_region_lock_manager import rblm_pkg::*; #(
  parameter int LOCK_SLOTS       = LOCK_SLOTS_DEF,
  parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,  // buffer_size
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] position_first, [63:32] position_second, [95:64] byte_count,
  // [96] wrap_flag, [97] has_second_part, rest zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,    // [1:0] action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [16:0] part1_offset, [33:17] part1_length, [34] has_part2,
  // [51:35] part2_length, [69:52] total_bytes, [86:70] read_position,
  // [103:87] write_position, [121:104] lockable_bytes, rest zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser     // [1:0] status
);
  localparam int SW = size_width(MAX_BUFFER_BYTES);

  logic [CFG_W-1:0] buffer_size;
  logic [SW-1:0]    size_eff;
  logic             q_push, q_pop, q_full, q_valid;
  item_t            push_item, head_item;

  // Hold the size register; zero or oversize falls back to the maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

  assign size_eff = ((buffer_size == '0) || (32'(buffer_size) > 32'(MAX_BUFFER_BYTES))) ?
                    SW'(MAX_BUFFER_BYTES) : SW'(buffer_size);

  // Classify incoming words.
  rblm_front #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_front (
    .size    (size_eff),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (push_item)
  );

  // Decouple the two sides.
  rblm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (head_item)
  );

  // Execute against positions and the lock table.
  rblm_back #(
    .LOCK_SLOTS      (LOCK_SLOTS),
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .size    (size_eff),
    .q_valid (q_valid),
    .q_item  (head_item),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  `ASSERT_IMPL(a_status_known, clk, rst, m_tvalid, (m_tuser == ST_OK) || (m_tuser == ST_INVALID) || (m_tuser == ST_FULL), "reserved status code")
  `ASSERT_IMPL(a_full_no_span, clk, rst, m_tvalid && (m_tuser == ST_FULL), m_tdata[69:0] == 70'd0, "full table result carries a span")
  `ASSERT_IMPL(a_no_part2_len, clk, rst, m_tvalid && !m_tdata[34], m_tdata[51:35] == 17'd0, "second length without second part")
  `ASSERT_NEXT(a_pop_empty, clk, rst, q_pop, !q_pop, "back end popped twice in a row")
endmodule
